/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising edge of clk_i, off while rst_ni is low.
`define TLRR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same check, also active while reset is asserted.
`define TLRR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* hw/rtl/tlrr_pkg.sv */
// Package: types and constants of the tape level run-length recorder.
`default_nettype none

package tlrr_pkg;

  localparam int unsigned COUNT_WIDTH  = 32;
  localparam int unsigned PERIOD_WIDTH = 16;
  localparam int unsigned CFG_WIDTH    = 16;
  localparam int unsigned KIND_WIDTH   = 2;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = PERIOD_WIDTH'(79);
  localparam logic [COUNT_WIDTH-1:0]  COUNT_MAX    = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0]  COUNT_ONE    = COUNT_WIDTH'(1);

  typedef enum logic [KIND_WIDTH-1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2
  } kind_e;

  // One finished run handed from the front to the back.
  typedef struct packed {
    logic [COUNT_WIDTH-1:0] count;
    logic                   end_of_take;
  } run_cmd_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/tlrr_front.sv */
// Front: takes input transactions, runs prescaler and run counter, issues runs.
`default_nettype none

module tlrr_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tlrr_pkg::CFG_WIDTH-1:0] cfg_wdata_i,
  input  logic                          accept_i,
  input  logic [tlrr_pkg::KIND_WIDTH-1:0] kind_i,
  input  logic                          tape_level_i,
  output logic                          push_o,
  output tlrr_pkg::run_cmd_t            cmd_o
);
  import tlrr_pkg::*;

  logic [PERIOD_WIDTH-1:0] period_q, period_d;
  logic [PERIOD_WIDTH-1:0] pre_q, pre_d;
  logic [COUNT_WIDTH-1:0]  cnt_q, cnt_d;
  logic                    rec_q, rec_d;
  logic                    prev_q, prev_d;
  logic [PERIOD_WIDTH:0]   pre_next;
  kind_e                   kind;

  assign kind     = kind_e'(kind_i);
  assign pre_next = {1'b0, pre_q} + (PERIOD_WIDTH+1)'(1);
  assign period_d = cfg_we_i ? PERIOD_WIDTH'(cfg_wdata_i) : period_q;

  always_comb begin
    rec_d             = rec_q;
    prev_d            = prev_q;
    cnt_d             = cnt_q;
    pre_d             = pre_q;
    push_o            = 1'b0;
    cmd_o.count       = cnt_q;
    cmd_o.end_of_take = 1'b0;
    if (accept_i) begin
      case (kind)
        KIND_START: begin
          rec_d  = 1'b1;
          prev_d = tape_level_i;
          cnt_d  = COUNT_ONE;
          pre_d  = '0;
        end
        KIND_STOP: begin
          if (rec_q) begin
            push_o            = 1'b1;
            cmd_o.end_of_take = 1'b1;
            rec_d             = 1'b0;
          end
        end
        KIND_TICK: begin
          if (rec_q) begin
            if (pre_next < {1'b0, period_q}) begin
              pre_d = pre_next[PERIOD_WIDTH-1:0];
            end else begin
              pre_d = '0;
              if (tape_level_i != prev_q) begin
                push_o = 1'b1;
                prev_d = tape_level_i;
                cnt_d  = COUNT_ONE;
              end else if (cnt_q != COUNT_MAX) begin
                cnt_d = cnt_q + COUNT_ONE;
              end
            end
          end
        end
        default: begin
          // unused kind: drop
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
      pre_q    <= '0;
      cnt_q    <= '0;
      rec_q    <= 1'b0;
      prev_q   <= 1'b0;
    end else begin
      period_q <= period_d;
      pre_q    <= pre_d;
      cnt_q    <= cnt_d;
      rec_q    <= rec_d;
      prev_q   <= prev_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tlrr_queue.sv */
// Short run queue between the front and the back.
`default_nettype none

module tlrr_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tlrr_pkg::run_cmd_t push_cmd_i,
  input  logic               pop_i,
  output tlrr_pkg::run_cmd_t head_o,
  output tlrr_pkg::q_stat_t  stat_o
);
  import tlrr_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  run_cmd_t         mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign stat_o.not_empty = (cnt_q != '0);
  assign stat_o.full      = (cnt_q == CNT_FULL);
  assign do_push          = push_i && !stat_o.full;
  assign do_pop           = pop_i && stat_o.not_empty;
  assign head_o           = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tlrr_back.sv */
// Back: turns queued runs into coded bytes and holds the output register.
`default_nettype none

module tlrr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tlrr_pkg::q_stat_t  q_stat_i,
  input  tlrr_pkg::run_cmd_t head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         data_byte_o,
  output logic               last_of_run_o,
  output logic               end_of_take_o
);
  import tlrr_pkg::*;

  localparam logic [2:0] IDX_MARK = 3'd0;
  localparam logic [2:0] IDX_B0   = 3'd1;
  localparam logic [2:0] IDX_B1   = 3'd2;
  localparam logic [2:0] IDX_B2   = 3'd3;
  localparam logic [2:0] IDX_B3   = 3'd4;

  logic [2:0]  idx_q, idx_d;
  logic        valid_q, valid_d;
  logic [7:0]  data_q, data_d;
  logic        last_q, last_d;
  logic        eot_q, eot_d;
  logic [31:0] count32;
  logic        is_short;
  logic        advance;
  logic        produce;

  assign count32  = 32'(head_i.count);
  assign is_short = (count32[31:8] == '0);
  assign advance  = !valid_q || !out_stall_i;
  assign produce  = advance && q_stat_i.not_empty;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    data_d  = data_q;
    last_d  = last_q;
    eot_d   = eot_q;
    pop_o   = 1'b0;
    if (advance) begin
      valid_d = produce;
    end
    if (produce) begin
      last_d = 1'b0;
      eot_d  = 1'b0;
      if (is_short) begin
        data_d = count32[7:0];
        last_d = 1'b1;
        eot_d  = head_i.end_of_take;
        pop_o  = 1'b1;
      end else begin
        idx_d = idx_q + 3'd1;
        case (idx_q)
          IDX_MARK: data_d = 8'h00;
          IDX_B0:   data_d = count32[7:0];
          IDX_B1:   data_d = count32[15:8];
          IDX_B2:   data_d = count32[23:16];
          IDX_B3: begin
            data_d = count32[31:24];
            last_d = 1'b1;
            eot_d  = head_i.end_of_take;
            pop_o  = 1'b1;
            idx_d  = IDX_MARK;
          end
          default: begin
            data_d = 8'h00;
            idx_d  = IDX_MARK;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= IDX_MARK;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
    eot_q  <= eot_d;
  end

  assign out_valid_o   = valid_q;
  assign data_byte_o   = data_q;
  assign last_of_run_o = last_q;
  assign end_of_take_o = eot_q;

endmodule

`default_nettype wire

/* hw/rtl/tape_level_run_length_recorder_core.sv */
// Top level: tape level run-length recorder, front, run queue and byte back end.
// Throughput: one input transaction per cycle while the two-entry run queue has room.
// Output: one byte per cycle unless stalled; short runs take one byte, long runs five.
// Path: with the queue empty, the first byte of a run passes the queue entry and then
//   the output register after the transaction that finishes it.
// Reset: asynchronous, active low; idle, counters cleared, sample_period = 79.
`default_nettype none
`include "assert_macros.svh"

module tape_level_run_length_recorder_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration: sample_period
  input  logic                            cfg_we_i,
  input  logic [tlrr_pkg::CFG_WIDTH-1:0]  cfg_wdata_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [tlrr_pkg::KIND_WIDTH-1:0] kind_i,
  input  logic                            tape_level_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      data_byte_o,
  output logic                            last_of_run_o,
  output logic                            end_of_take_o
);
  import tlrr_pkg::*;

  logic     in_accept;
  logic     push;
  logic     pop;
  run_cmd_t push_cmd;
  run_cmd_t head;
  q_stat_t  q_stat;

  // Hold the input while the queue has no slot; a transaction may finish a run.
  assign in_stall_o = q_stat.full;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Front: prescaler, level compare and saturating run counter.
  tlrr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .accept_i     (in_accept),
    .kind_i       (kind_i),
    .tape_level_i (tape_level_i),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  // Decouple run production from byte output.
  tlrr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  // Back: advance one byte per free output slot, pop after the last byte of a run.
  tlrr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_stat_i      (q_stat),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .data_byte_o   (data_byte_o),
    .last_of_run_o (last_of_run_o),
    .end_of_take_o (end_of_take_o)
  );

  // A run is never pushed into a full queue.
  `TLRR_ASSERT(a_no_overflow, push |-> !q_stat.full, "run pushed into full queue")
  // A run is popped only after it was queued.
  `TLRR_ASSERT(a_no_underflow, pop |-> q_stat.not_empty, "pop from empty queue")
  // Mid-run byte on the output: its run still waits at the queue head.
  `TLRR_ASSERT(a_long_run_held, (out_valid_o && !last_of_run_o) |-> q_stat.not_empty,
    "long run left the queue before its last byte")
  // End of take only marks the final byte of a run.
  `TLRR_ASSERT(a_eot_on_last, (out_valid_o && end_of_take_o) |-> last_of_run_o,
    "end_of_take without last_of_run")

endmodule

`default_nettype wire
